// ===== rtl/vrth_pkg.sv =====
// Shared widths, item types and pipeline payload types for the vertical ray height probe.
package vrth_pkg;

    localparam int CW   = 32;
    localparam int DW   = CW + 1;
    localparam int PW   = 2 * DW;
    localparam int NW   = PW + 1;
    localparam int LW   = DW + 1;
    localparam int HW   = NW - LW;
    localparam int MW   = NW + DW;
    localparam int NUMW = MW + 1;
    localparam int QW   = DW + 1;
    localparam int RW   = NW + 1;

    typedef struct packed {
        logic signed [CW-1:0] query_x;
        logic signed [CW-1:0] query_z;
        logic signed [CW-1:0] v0_x;
        logic signed [CW-1:0] v0_y;
        logic signed [CW-1:0] v0_z;
        logic signed [CW-1:0] v1_x;
        logic signed [CW-1:0] v1_y;
        logic signed [CW-1:0] v1_z;
        logic signed [CW-1:0] v2_x;
        logic signed [CW-1:0] v2_y;
        logic signed [CW-1:0] v2_z;
    } t_item;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] surface_height;
    } t_result;

    typedef struct packed {
        logic                 hit;
        logic        [NW-1:0] d;
        logic signed [NW-1:0] sn;
        logic signed [NW-1:0] tn;
        logic signed [DW-1:0] uy;
        logic signed [DW-1:0] vy;
        logic signed [CW-1:0] ay;
    } t_geo;

    typedef struct packed {
        logic                 hit;
        logic                 neg;
        logic        [MW-1:0] mag;
        logic        [NW-1:0] d;
        logic signed [CW-1:0] ay;
    } t_num;

endpackage

// ===== rtl/vrth_geom.sv =====
// Edge vectors, cross products, sign normalization and inside test.
module vrth_geom (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  vrth_pkg::t_item i_item,
    output logic           o_valid,
    output vrth_pkg::t_geo o_geo
);
    import vrth_pkg::*;

    logic r_v1, r_v2, r_v3, r_v4;
    logic signed [DW-1:0] r_ux, r_uz, r_vx, r_vz, r_wx, r_wz, r_uy, r_vy;
    logic signed [CW-1:0] r_ay1, r_ay2, r_ay3;
    logic signed [DW-1:0] r_uy2, r_vy2, r_uy3, r_vy3;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [NW-1:0] r_d, r_sn, r_tn;
    t_geo r_geo, n_geo;

    logic signed [NW-1:0] dn, snn, tnn;
    logic signed [NW+1:0] slack;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ux  <= DW'(i_item.v1_x) - DW'(i_item.v0_x);
        r_uy  <= DW'(i_item.v1_y) - DW'(i_item.v0_y);
        r_uz  <= DW'(i_item.v1_z) - DW'(i_item.v0_z);
        r_vx  <= DW'(i_item.v2_x) - DW'(i_item.v0_x);
        r_vy  <= DW'(i_item.v2_y) - DW'(i_item.v0_y);
        r_vz  <= DW'(i_item.v2_z) - DW'(i_item.v0_z);
        r_wx  <= DW'(i_item.query_x) - DW'(i_item.v0_x);
        r_wz  <= DW'(i_item.query_z) - DW'(i_item.v0_z);
        r_ay1 <= i_item.v0_y;

        r_p0  <= r_ux * r_vz;
        r_p1  <= r_uz * r_vx;
        r_p2  <= r_wx * r_vz;
        r_p3  <= r_wz * r_vx;
        r_p4  <= r_ux * r_wz;
        r_p5  <= r_uz * r_wx;
        r_uy2 <= r_uy;
        r_vy2 <= r_vy;
        r_ay2 <= r_ay1;

        r_d   <= NW'(r_p0) - NW'(r_p1);
        r_sn  <= NW'(r_p2) - NW'(r_p3);
        r_tn  <= NW'(r_p4) - NW'(r_p5);
        r_uy3 <= r_uy2;
        r_vy3 <= r_vy2;
        r_ay3 <= r_ay2;

        r_geo <= n_geo;
    end

    always_comb begin
        dn    = r_d[NW-1] ? -r_d  : r_d;
        snn   = r_d[NW-1] ? -r_sn : r_sn;
        tnn   = r_d[NW-1] ? -r_tn : r_tn;
        slack = (NW+2)'(dn) - (NW+2)'(snn) - (NW+2)'(tnn);
        n_geo.hit = (r_d != '0) && !snn[NW-1] && !tnn[NW-1] && !slack[NW+1];
        n_geo.d   = dn;
        n_geo.sn  = snn;
        n_geo.tn  = tnn;
        n_geo.uy  = r_uy3;
        n_geo.vy  = r_vy3;
        n_geo.ay  = r_ay3;
    end

    assign o_valid = r_v4;
    assign o_geo   = r_geo;
endmodule

// ===== rtl/vrth_numer.sv =====
// Height numerator from split partial products, then sign and magnitude.
module vrth_numer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  vrth_pkg::t_geo i_geo,
    output logic           o_valid,
    output vrth_pkg::t_num o_num
);
    import vrth_pkg::*;

    logic r_v1, r_v2, r_v3;
    logic signed [LW+DW:0]  r_slo, r_tlo;
    logic signed [HW+DW-1:0] r_shi, r_thi;
    logic signed [NUMW-1:0] r_num;
    logic        [NW-1:0]   r_d1, r_d2;
    logic signed [CW-1:0]   r_ay1, r_ay2;
    logic                   r_h1, r_h2;
    t_num r_out;

    logic signed [LW:0]   s_lo, t_lo;
    logic signed [HW-1:0] s_hi, t_hi;
    logic signed [NUMW-1:0] hi_sum;

    assign s_lo = $signed({1'b0, i_geo.sn[LW-1:0]});
    assign t_lo = $signed({1'b0, i_geo.tn[LW-1:0]});
    assign s_hi = i_geo.sn[NW-1:LW];
    assign t_hi = i_geo.tn[NW-1:LW];
    assign hi_sum = NUMW'(r_shi) + NUMW'(r_thi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slo <= s_lo * i_geo.uy;
        r_tlo <= t_lo * i_geo.vy;
        r_shi <= s_hi * i_geo.uy;
        r_thi <= t_hi * i_geo.vy;
        r_d1  <= i_geo.d;
        r_ay1 <= i_geo.ay;
        r_h1  <= i_geo.hit;

        r_num <= (hi_sum <<< LW) + NUMW'(r_slo) + NUMW'(r_tlo);
        r_d2  <= r_d1;
        r_ay2 <= r_ay1;
        r_h2  <= r_h1;

        r_out.hit <= r_h2;
        r_out.neg <= r_num[NUMW-1];
        r_out.mag <= r_num[NUMW-1] ? MW'(-r_num) : MW'(r_num);
        r_out.d   <= r_d2;
        r_out.ay  <= r_ay2;
    end

    assign o_valid = r_v3;
    assign o_num   = r_out;
endmodule

// ===== rtl/vrth_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with rounding and final height.
module vrth_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  vrth_pkg::t_num    i_num,
    output logic              o_valid,
    output vrth_pkg::t_result o_result
);
    import vrth_pkg::*;

    typedef struct packed {
        logic                 hit;
        logic                 neg;
        logic signed [CW-1:0] ay;
        logic        [NW-1:0] d;
        logic        [RW-1:0] rem;
        logic        [QW-1:0] low;
        logic        [QW-1:0] q;
    } t_dstage;

    function automatic t_dstage div_step(input t_dstage a);
        t_dstage        b;
        logic [RW-1:0]  trial;
        b = a;
        trial = {a.rem[RW-2:0], a.low[QW-1]};
        b.low = a.low << 1;
        if (trial >= RW'(a.d)) begin
            b.rem = trial - RW'(a.d);
            b.q   = {a.q[QW-2:0], 1'b1};
        end else begin
            b.rem = trial;
            b.q   = {a.q[QW-2:0], 1'b0};
        end
        return b;
    endfunction

    t_dstage r_st [QW];
    logic    [QW-1:0] r_vld;
    t_dstage init;
    logic    r_vout;
    t_result r_res;

    logic [RW-1:0]        rem2;
    logic                 rnd;
    logic signed [CW-1:0] qr, h;

    always_comb begin
        init.hit = i_num.hit;
        init.neg = i_num.neg;
        init.ay  = i_num.ay;
        init.d   = i_num.d;
        init.rem = RW'(i_num.mag[MW-1:QW]);
        init.low = i_num.mag[QW-1:0];
        init.q   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_vout <= 1'b0;
        end else begin
            r_vld  <= {r_vld[QW-2:0], i_valid};
            r_vout <= r_vld[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= div_step(init);
        for (int k = 1; k < QW; k++) begin
            r_st[k] <= div_step(r_st[k-1]);
        end
    end

    always_comb begin
        rem2 = r_st[QW-1].rem << 1;
        rnd  = rem2 >= RW'(r_st[QW-1].d);
        qr   = CW'(r_st[QW-1].q) + CW'(rnd);
        h    = r_st[QW-1].ay + (r_st[QW-1].neg ? -qr : qr);
    end

    always_ff @(posedge i_clk) begin
        r_res.hit            <= r_st[QW-1].hit;
        r_res.surface_height <= r_st[QW-1].hit ? h : '0;
    end

    assign o_valid  = r_vout;
    assign o_result = r_res;
endmodule

// ===== rtl/vertical_ray_triangle_height.sv =====
// Top level of the vertical ray / triangle height probe.
// One item (query point plus triangle) is taken every cycle; busy is always low.
// Each item gives one result, strobed by o_valid for one cycle, in order. The
// result passes through the 34-stage divider, one quotient bit per stage,
// behind 7 stages of edge, cross product and numerator arithmetic,
// and is followed by one rounding and output register.
// The receiver cannot stall, so results must be taken when strobed.
module vertical_ray_triangle_height (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  vrth_pkg::t_item   i_item,
    output logic              o_valid,
    output vrth_pkg::t_result o_result
);
    import vrth_pkg::*;

    logic g_valid, n_valid;
    t_geo g_geo;
    t_num n_num;

    assign busy = 1'b0;

    vrth_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_item  (i_item),
        .o_valid (g_valid),
        .o_geo   (g_geo)
    );

    vrth_numer u_numer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (g_valid),
        .i_geo   (g_geo),
        .o_valid (n_valid),
        .o_num   (n_num)
    );

    vrth_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (n_valid),
        .i_num    (n_num),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.hit) |-> (o_result.surface_height == '0))
        else $error("miss with nonzero height");

    a_geo_hit_nonzero_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (g_valid && g_geo.hit) |-> (g_geo.d != '0))
        else $error("hit on degenerate triangle");

    a_num_follows_geo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        g_valid |-> ##3 n_valid)
        else $error("item lost in numerator stages");
endmodule

// ===== verif/vrth_checker.sv =====
// Checker for the vertical ray height probe: predicts each item's result and compares in order.
`timescale 1ns / 1ps
module vrth_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  vrth_pkg::t_item   i_item,
    input  logic              o_valid,
    input  vrth_pkg::t_result o_result,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_hit_count,
    output int                o_result_count
);
    import vrth_pkg::*;

    typedef logic signed [127:0] t_wide;

    t_result height_queue[$];
    int      mismatches;
    int      orphans;

    function automatic t_result predict_height(t_item it);
        t_wide   ux, uy, uz, vx, vy, vz, wx, wz, ay;
        t_wide   d, sn, tn, num, mag, q, r;
        logic    neg;
        t_result res;
        ay  = t_wide'(it.v0_y);
        ux  = t_wide'(it.v1_x) - t_wide'(it.v0_x);
        uy  = t_wide'(it.v1_y) - ay;
        uz  = t_wide'(it.v1_z) - t_wide'(it.v0_z);
        vx  = t_wide'(it.v2_x) - t_wide'(it.v0_x);
        vy  = t_wide'(it.v2_y) - ay;
        vz  = t_wide'(it.v2_z) - t_wide'(it.v0_z);
        wx  = t_wide'(it.query_x) - t_wide'(it.v0_x);
        wz  = t_wide'(it.query_z) - t_wide'(it.v0_z);
        d   = ux * vz - uz * vx;
        sn  = wx * vz - wz * vx;
        tn  = ux * wz - uz * wx;
        res = '0;
        if (d == 0) begin
            return res;
        end
        if (d < 0) begin
            d  = -d;
            sn = -sn;
            tn = -tn;
        end
        if (sn < 0 || tn < 0 || (d - sn - tn) < 0) begin
            return res;
        end
        num = sn * uy + tn * vy;
        neg = num < 0;
        mag = neg ? -num : num;
        q   = $unsigned(mag) / $unsigned(d);
        r   = mag - q * d;
        if (2 * r >= d) begin
            q = q + 1;
        end
        res.hit            = 1'b1;
        res.surface_height = CW'(ay + (neg ? -q : q));
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            height_queue.delete();
            mismatches     <= 0;
            orphans        <= 0;
            o_hit_count    <= 0;
            o_result_count <= 0;
        end else begin
            if (start && !busy) begin
                height_queue.push_back(predict_height(i_item));
            end
            if (o_valid) begin
                o_result_count <= o_result_count + 1;
                if (o_result.hit) begin
                    o_hit_count <= o_hit_count + 1;
                end
                if (height_queue.size() == 0) begin
                    orphans <= orphans + 1;
                    $display("ERROR: result with no item pending: hit=%0b height=%h",
                             o_result.hit, o_result.surface_height);
                end else begin
                    want = height_queue.pop_front();
                    if (want.hit !== o_result.hit ||
                        want.surface_height !== o_result.surface_height) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10) begin
                            $display("MISMATCH: exp hit=%0b height=%h, got hit=%0b height=%h",
                                     want.hit, want.surface_height,
                                     o_result.hit, o_result.surface_height);
                        end
                    end
                end
            end
        end
    end

    assign o_pending    = height_queue.size();
    assign o_fail_count = mismatches + orphans;
endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the vertical ray height probe: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
    import vrth_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int MIN_C = -2147483647 - 1;
    localparam int MAX_C = 2147483647;
    localparam int ONE   = 32'h0001_0000;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_item   i_item = '0;
    logic    o_valid;
    t_result o_result;
    int      fail_count, pending, hit_count, result_count;
    int      cycles = 0;
    int      idle_pct;
    int      sent = 0;

    always #1 i_clk = ~i_clk;

    vertical_ray_triangle_height DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_valid(o_valid), .o_result(o_result)
    );

    vrth_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_valid(o_valid), .o_result(o_result),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_hit_count(hit_count), .o_result_count(result_count)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic t_item mk(int qx, int qz, int ax, int ay, int az,
                                 int bx, int by, int bz, int cx, int cy, int cz);
        t_item it;
        it = '{qx, qz, ax, ay, az, bx, by, bz, cx, cy, cz};
        return it;
    endfunction

    function automatic int near(int base, int span);
        return base + $signed($urandom_range(2 * span)) - span;
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    span, kind;
        logic [CW*11-1:0] raw;
        kind = $urandom_range(99);
        if (kind < 25) begin
            for (int k = 0; k < 11; k++) begin
                raw[k*CW +: CW] = $urandom;
            end
            it = raw;
        end else begin
            span = (kind < 85) ? (1 << $urandom_range(4, 22)) : (1 << 29);
            it.v0_x = near(0, span);
            it.v0_z = near(0, span);
            it.v1_x = near(0, span);
            it.v1_z = near(0, span);
            it.v2_x = near(0, span);
            it.v2_z = near(0, span);
            it.v0_y = $urandom;
            it.v1_y = (kind < 60) ? near(it.v0_y >>> 2, span) : $urandom;
            it.v2_y = (kind < 60) ? near(it.v0_y >>> 2, span) : $urandom;
            if (kind < 90) begin
                it.query_x = near((it.v0_x + it.v1_x + it.v2_x) / 3, span / 4);
                it.query_z = near((it.v0_z + it.v1_z + it.v2_z) / 3, span / 4);
            end else begin
                it.query_x = near(it.v1_x, 2);
                it.query_z = near(it.v1_z, 2);
            end
        end
        return it;
    endfunction

    task automatic send_item(t_item it);
        logic was_busy;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do begin
            @(negedge i_clk);
            was_busy = busy;
            @(posedge i_clk);
        end while (was_busy);
        sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        t_item directed[$];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unit right triangle: interior, vertex, hypotenuse, outside each side
        directed.push_back(mk(ONE/4, ONE/4, 0, 0, 0, ONE, ONE, 0, 0, 2*ONE, ONE));
        directed.push_back(mk(0, 0, 0, 5, 0, ONE, ONE, 0, 0, 2*ONE, ONE));
        directed.push_back(mk(ONE/2, ONE/2, 0, 0, 0, ONE, ONE, 0, 0, 2*ONE, ONE));
        directed.push_back(mk(-1, ONE/4, 0, 0, 0, ONE, ONE, 0, 0, 2*ONE, ONE));
        directed.push_back(mk(ONE/4, -1, 0, 0, 0, ONE, ONE, 0, 0, 2*ONE, ONE));
        directed.push_back(mk(ONE/2, ONE/2+1, 0, 0, 0, ONE, ONE, 0, 0, 2*ONE, ONE));
        // flipped winding gives negative determinant
        directed.push_back(mk(ONE/4, ONE/4, 0, 0, 0, 0, 2*ONE, ONE, ONE, ONE, 0));
        // colinear, coincident and vertical-plane triangles
        directed.push_back(mk(ONE, ONE, 0, 0, 0, ONE, 7, ONE, 2*ONE, 9, 2*ONE));
        directed.push_back(mk(3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3));
        directed.push_back(mk(ONE, 0, 0, 0, 0, 2*ONE, 0, 0, ONE, ONE, 0));
        // rounding ties, both signs
        directed.push_back(mk(1, 0, 0, 0, 0, 2, 1, 0, 0, 0, 2));
        directed.push_back(mk(1, 0, 0, 0, 0, 2, -1, 0, 0, 0, 2));
        directed.push_back(mk(1, 0, 0, 0, 0, 2, 3, 0, 0, 0, 2));
        // full-range triangles
        directed.push_back(mk(MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MAX_C, MAX_C, MIN_C,
                              MIN_C, MAX_C, MAX_C));
        directed.push_back(mk(0, 0, MIN_C, MIN_C, MIN_C, MAX_C, MAX_C, MIN_C,
                              MIN_C, MAX_C, MAX_C));
        directed.push_back(mk(MAX_C, MAX_C, MIN_C, MAX_C, MIN_C, MAX_C, MIN_C, MIN_C,
                              MIN_C, MIN_C, MAX_C));
        directed.push_back(mk(MIN_C, MAX_C, MIN_C, MIN_C, MIN_C, MAX_C, MAX_C, MIN_C,
                              MIN_C, MAX_C, MAX_C));
        directed.push_back(mk(-ONE, -ONE, MIN_C, MAX_C, MIN_C, MAX_C, MIN_C, MAX_C,
                              MAX_C, MAX_C, MIN_C));
        directed.push_back(mk(MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C,
                              MAX_C, MAX_C, MAX_C));
        directed.push_back(mk(MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C,
                              MIN_C, MIN_C, MIN_C));
        directed.push_back('1);
        directed.push_back('0);

        idle_pct = 0;
        foreach (directed[k]) send_item(directed[k]);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 34 : (phase == 1) ? 62 : 0;
            for (int k = 0; k < 570; k++) begin
                send_item(random_item());
            end
            drain();
        end

        repeat (60) @(posedge i_clk);
        $display("Covered %0d items (directed extremes, degenerate and edge cases, random).",
                 sent);
        $display("Results seen: %0d, hits: %0d, failures: %0d.",
                 result_count, hit_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ===== vertical_ray_triangle_height.f =====
rtl/vrth_pkg.sv
rtl/vrth_geom.sv
rtl/vrth_numer.sv
rtl/vrth_div.sv
rtl/vertical_ray_triangle_height.sv
verif/vrth_checker.sv
verif/tb_top.sv
